// ===== rtl/fvn_pkg.sv =====
`timescale 1ns / 1ps
// Package for the fbm value noise shader: widths, hash primes, fade and lerp
// arithmetic, quarter-wave sine table and glyph table. No dependencies.
package fvn_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP    = 8'd1;
  localparam logic [STEP_W-1:0]    COLUMN_STEP_RST = 16'd655;
  localparam logic [STEP_W-1:0]    ROW_STEP_RST    = 16'd328;

  localparam int unsigned OCTAVES = 4;
  localparam int unsigned DEN     = (1 << OCTAVES) - 1;
  localparam int unsigned SUM_W   = 16 + OCTAVES;
  localparam int unsigned RSH     = SUM_W + OCTAVES;
  localparam int unsigned RECIP_W = RSH + 1;
  localparam logic [63:0] RECIP   = ((64'd1 << RSH) + 64'(DEN) - 64'd1) / 64'(DEN);

  localparam logic [31:0] PRIME [3] = '{32'd73856093, 32'd19349663, 32'd83492791};
  localparam logic [31:0] AV_C1 = 32'h7feb352d;
  localparam logic [31:0] AV_C2 = 32'h846ca68b;

  localparam logic [15:0] W_NOISE = 16'd42598;
  localparam logic [15:0] W_BANDS = 16'd22938;

  localparam int unsigned SINE_BITS = 10;
  localparam int unsigned SINE_N    = 1 << SINE_BITS;
  localparam int unsigned QUARTER   = SINE_N / 4;
  localparam int unsigned KK_W      = SINE_BITS - 1;
  localparam int unsigned SINE_HALF = 1 << (15 - SINE_BITS);
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  localparam logic [7:0] RAMP [6] = '{8'h20, 8'h2E, 8'h2B, 8'h31, 8'h30, 8'h30};

  typedef logic [15:0] qsine_t [QUARTER+1];
  typedef logic [7:0]  glyph_tab_t [256];

  function automatic qsine_t build_qsine();
    qsine_t tab;
    logic [63:0] x, x2, term, pos, neg, m;
    for (int unsigned kk = 0; kk <= QUARTER; kk++) begin
      x    = (64'(kk) * TWO_PI_Q30) >> SINE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int unsigned j = 1; j <= 7; j++) begin
        term = ((term * x2) >> 30) / 64'((2 * j) * (2 * j + 1));
        if ((j & 1) != 0) neg = neg + term;
        else pos = pos + term;
      end
      m = (pos > neg) ? pos - neg : 64'd0;
      m = (m + 64'd16384) >> 15;
      tab[kk] = m[15:0];
    end
    return tab;
  endfunction

  function automatic glyph_tab_t build_glyph();
    glyph_tab_t tab;
    int unsigned idx;
    for (int unsigned i = 0; i < 256; i++) begin
      idx = (i * 10 + 255) / 510;
      tab[i] = RAMP[idx];
    end
    return tab;
  endfunction

  localparam qsine_t     QSINE = build_qsine();
  localparam glyph_tab_t GLYPH = build_glyph();

  // one rounded Q0.16 power step: (prev * t + 0.5) >> 16
  function automatic logic [15:0] pow_step(logic [15:0] prev, logic [15:0] t);
    logic [32:0] m;
    m = 33'(prev) * 33'(t) + 33'd32768;
    return m[31:16];
  endfunction

  function automatic logic [15:0] fade_sum(logic [15:0] t3, logic [15:0] t4,
                                           logic [15:0] t5);
    logic signed [21:0] s;
    s = signed'({6'b0, t3}) * 22'sd10 - signed'({6'b0, t4}) * 22'sd15
      + signed'({6'b0, t5}) * 22'sd6;
    if (s < 22'sd0) return 16'd0;
    else if (s > 22'sd65535) return 16'hFFFF;
    else return s[15:0];
  endfunction

  function automatic logic [15:0] lerp16(logic [15:0] a, logic [15:0] b,
                                         logic [15:0] s);
    logic signed [16:0] d;
    logic signed [33:0] p;
    d = signed'({1'b0, b}) - signed'({1'b0, a});
    p = signed'({1'b0, s}) * d + 34'sd32768;
    return a + p[31:16];
  endfunction

  function automatic logic [31:0] mix1(logic [31:0] h);
    logic [31:0] g;
    g = h ^ (h >> 16);
    return g * AV_C1;
  endfunction

  function automatic logic [15:0] mix2(logic [31:0] h);
    logic [31:0] g;
    g = (h ^ (h >> 15)) * AV_C2;
    return g[31:16];
  endfunction

endpackage

// ===== rtl/fvn_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the fbm value noise shader: pixel in, shade out,
// register write. Depends on fvn_pkg for widths.
interface fvn_in_if;
  logic                            valid;
  logic                            ready;
  logic [fvn_pkg::COORD_W-1:0]     column;
  logic [fvn_pkg::COORD_W-1:0]     row;
  logic [fvn_pkg::TIME_W-1:0]      time_coord;
  modport source(output valid, column, row, time_coord, input ready);
  modport sink(input valid, column, row, time_coord, output ready);
endinterface

interface fvn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] noise_value;
  logic [7:0]  shade_index;
  logic [7:0]  glyph;
  modport source(output valid, noise_value, shade_index, glyph, input ready);
  modport sink(input valid, noise_value, shade_index, glyph, output ready);
endinterface

interface fvn_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fvn_pkg::CFG_IDX_W-1:0]    index;
  logic [fvn_pkg::CFG_DATA_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/fbm_value_noise_shader.sv =====
`timescale 1ns / 1ps
// Top level of the fbm value noise shader, a 13-stage pixel pipeline.
// Depends on fvn_pkg and the channel interfaces in fvn_if.sv.
//
//   channel  dir  payload                              handshake
//   in_ch    in   column, row, time_coord              valid/ready
//   out_ch   out  noise_value, shade_index, glyph      valid/ready
//   cfg_ch   in   index, data                          valid/ready, ready always high
//
// One word per cycle while out_ch.ready lets the last stage drain; every stage is registered.
// Stage count is set by the hash multiplier chain, fade powers, lerp tree, octave sum, band lookup and shade mix.
// Each stage holds its word while the stage after it is full and stalled,
// so bubbles collapse and no word is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads default steps.
module fbm_value_noise_shader (
  input  logic             clk,
  input  logic             rst_n,
  fvn_in_if.sink           in_ch,
  fvn_out_if.source        out_ch,
  fvn_cfg_if.sink          cfg_ch
);

  localparam int unsigned NSTG = 13;
  localparam int unsigned O    = fvn_pkg::OCTAVES;
  localparam int unsigned PW   = fvn_pkg::SUM_W + 1 + fvn_pkg::RECIP_W;

  logic [15:0] col_step_r, row_step_r;
  logic [NSTG-1:0] v_r, rdy;

  logic [27:0] cx_r, cy_r;
  logic [31:0] cz_r;
  logic [31:0] cc [3];
  logic [31:0] sc [O][3];

  logic [31:0] prod0_r [O][3];
  logic [31:0] prod1_r [O][3];
  logic [15:0] ft1_r [O][3], fp2_r [O][3];
  logic [31:0] hm1_r [O][8];
  logic [15:0] ft2_r [O][3], f2t3_r [O][3];
  logic [15:0] val3_r [O][8];
  logic [15:0] ft3_r [O][3], f3t3_r [O][3], f3t4_r [O][3];
  logic [15:0] val4_r [O][8];
  logic [15:0] f4t3_r [O][3], f4t4_r [O][3], f4t5_r [O][3];
  logic [15:0] val5_r [O][8];
  logic [15:0] s5_r [O][3];
  logic [15:0] la_r [O][4];
  logic [15:0] sy6_r [O], sz6_r [O];
  logic [15:0] lb_r [O][2];
  logic [15:0] sz7_r [O];
  logic [15:0] nv_r [O];
  logic [15:0] n9_r, n10_r, n11_r, n12_r;
  logic [15:0] mag_r;
  logic        neg_r;
  logic [31:0] mix_r;
  logic [7:0]  shade_r, glyph_r;

  logic [fvn_pkg::SUM_W-1:0] sum;
  logic [fvn_pkg::SUM_W-1:0] ext;
  logic [fvn_pkg::SUM_W:0]   xs;
  logic [PW-1:0]             prod;
  logic [PW-1:0]             q;
  logic [15:0]               n_nxt;
  logic [15:0]               phase, ksum;
  logic [fvn_pkg::SINE_BITS-1:0] k;
  logic [31:0]               kk32;
  logic [fvn_pkg::KK_W-1:0]  kk;
  logic                      neg_nxt;
  logic [16:0]               bsum;
  logic [15:0]               bands;
  logic [40:0]               spr;
  logic [7:0]                shade_nxt;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_step_r <= fvn_pkg::COLUMN_STEP_RST;
      row_step_r <= fvn_pkg::ROW_STEP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        fvn_pkg::REG_COLUMN_STEP: col_step_r <= cfg_ch.data;
        fvn_pkg::REG_ROW_STEP:    row_step_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // stall chain: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_ch.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_ch.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_comb begin
    cc[0] = {4'b0, cx_r};
    cc[1] = {4'b0, cy_r};
    cc[2] = cz_r;
    for (int o = 0; o < O; o++) begin
      for (int a = 0; a < 3; a++) begin
        sc[o][a] = cc[a] << o;
      end
    end
  end

  // lattice scaling, corner products, fade powers, hash, fade sum and lerp tree
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cx_r <= {16'b0, in_ch.column} * {12'b0, col_step_r};
      cy_r <= {16'b0, in_ch.row} * {12'b0, row_step_r};
      cz_r <= in_ch.time_coord;
    end
    if (rdy[1]) begin
      for (int o = 0; o < O; o++) begin
        for (int a = 0; a < 3; a++) begin
          prod0_r[o][a] <= {16'b0, sc[o][a][31:16]} * fvn_pkg::PRIME[a];
          prod1_r[o][a] <= {16'b0, (sc[o][a][31:16] + 16'd1)} * fvn_pkg::PRIME[a];
          ft1_r[o][a]   <= sc[o][a][15:0];
          fp2_r[o][a]   <= fvn_pkg::pow_step(sc[o][a][15:0], sc[o][a][15:0]);
        end
      end
    end
    if (rdy[2]) begin
      for (int o = 0; o < O; o++) begin
        for (int c = 0; c < 8; c++) begin
          hm1_r[o][c] <= fvn_pkg::mix1(
            (((c & 1) != 0) ? prod1_r[o][0] : prod0_r[o][0]) ^
            (((c & 2) != 0) ? prod1_r[o][1] : prod0_r[o][1]) ^
            (((c & 4) != 0) ? prod1_r[o][2] : prod0_r[o][2]));
        end
        for (int a = 0; a < 3; a++) begin
          ft2_r[o][a]  <= ft1_r[o][a];
          f2t3_r[o][a] <= fvn_pkg::pow_step(fp2_r[o][a], ft1_r[o][a]);
        end
      end
    end
    if (rdy[3]) begin
      for (int o = 0; o < O; o++) begin
        for (int c = 0; c < 8; c++) begin
          val3_r[o][c] <= fvn_pkg::mix2(hm1_r[o][c]);
        end
        for (int a = 0; a < 3; a++) begin
          ft3_r[o][a]  <= ft2_r[o][a];
          f3t3_r[o][a] <= f2t3_r[o][a];
          f3t4_r[o][a] <= fvn_pkg::pow_step(f2t3_r[o][a], ft2_r[o][a]);
        end
      end
    end
    if (rdy[4]) begin
      for (int o = 0; o < O; o++) begin
        for (int c = 0; c < 8; c++) begin
          val4_r[o][c] <= val3_r[o][c];
        end
        for (int a = 0; a < 3; a++) begin
          f4t3_r[o][a] <= f3t3_r[o][a];
          f4t4_r[o][a] <= f3t4_r[o][a];
          f4t5_r[o][a] <= fvn_pkg::pow_step(f3t4_r[o][a], ft3_r[o][a]);
        end
      end
    end
    if (rdy[5]) begin
      for (int o = 0; o < O; o++) begin
        for (int c = 0; c < 8; c++) begin
          val5_r[o][c] <= val4_r[o][c];
        end
        for (int a = 0; a < 3; a++) begin
          s5_r[o][a] <= fvn_pkg::fade_sum(f4t3_r[o][a], f4t4_r[o][a], f4t5_r[o][a]);
        end
      end
    end
    if (rdy[6]) begin
      for (int o = 0; o < O; o++) begin
        for (int j = 0; j < 4; j++) begin
          la_r[o][j] <= fvn_pkg::lerp16(val5_r[o][2*j], val5_r[o][2*j+1], s5_r[o][0]);
        end
        sy6_r[o] <= s5_r[o][1];
        sz6_r[o] <= s5_r[o][2];
      end
    end
    if (rdy[7]) begin
      for (int o = 0; o < O; o++) begin
        lb_r[o][0] <= fvn_pkg::lerp16(la_r[o][0], la_r[o][1], sy6_r[o]);
        lb_r[o][1] <= fvn_pkg::lerp16(la_r[o][2], la_r[o][3], sy6_r[o]);
        sz7_r[o]   <= sz6_r[o];
      end
    end
    if (rdy[8]) begin
      for (int o = 0; o < O; o++) begin
        nv_r[o] <= fvn_pkg::lerp16(lb_r[o][0], lb_r[o][1], sz7_r[o]);
      end
    end
  end

  // weighted octave sum, divide by 2^OCTAVES-1 through the reciprocal
  always_comb begin
    sum = '0;
    for (int o = 0; o < O; o++) begin
      ext       = '0;
      ext[15:0] = nv_r[o];
      sum       = sum + (ext << (O - 1 - o));
    end
    xs   = {1'b0, sum} + (fvn_pkg::SUM_W + 1)'(fvn_pkg::DEN / 2);
    prod = PW'(xs) * PW'(fvn_pkg::RECIP[fvn_pkg::RECIP_W-1:0]);
    q    = prod >> fvn_pkg::RSH;
    n_nxt = (q[PW-1:16] != '0) ? 16'hFFFF : q[15:0];
  end

  // band phase and quarter-wave table lookup
  always_comb begin
    phase = n9_r + {n9_r[13:0], 2'b00};
    ksum  = phase + 16'(fvn_pkg::SINE_HALF);
    k     = ksum[15:16-fvn_pkg::SINE_BITS];
    neg_nxt = 1'b0;
    if (32'(k) <= fvn_pkg::QUARTER) begin
      kk32 = 32'(k);
    end else if (32'(k) < 2 * fvn_pkg::QUARTER) begin
      kk32 = 2 * fvn_pkg::QUARTER - 32'(k);
    end else if (32'(k) < 3 * fvn_pkg::QUARTER) begin
      kk32    = 32'(k) - 2 * fvn_pkg::QUARTER;
      neg_nxt = 1'b1;
    end else begin
      kk32    = fvn_pkg::SINE_N - 32'(k);
      neg_nxt = 1'b1;
    end
    kk = kk32[fvn_pkg::KK_W-1:0];
  end

  always_comb begin
    bsum  = neg_r ? (17'h08000 - {1'b0, mag_r}) : (17'h08000 + {1'b0, mag_r});
    bands = bsum[16] ? 16'hFFFF : bsum[15:0];
    spr   = 41'(mix_r) * 41'd255 + 41'h0080000000;
    shade_nxt = (spr[40] != 1'b0) ? 8'hFF : spr[39:32];
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) n9_r <= n_nxt;
    if (rdy[10]) begin
      n10_r <= n9_r;
      mag_r <= fvn_pkg::QSINE[kk];
      neg_r <= neg_nxt;
    end
    if (rdy[11]) begin
      n11_r <= n10_r;
      mix_r <= 32'(n10_r) * 32'(fvn_pkg::W_NOISE) + 32'(bands) * 32'(fvn_pkg::W_BANDS);
    end
    if (rdy[12]) begin
      n12_r   <= n11_r;
      shade_r <= shade_nxt;
      glyph_r <= fvn_pkg::GLYPH[shade_nxt];
    end
  end

  assign out_ch.valid       = v_r[NSTG-1];
  assign out_ch.noise_value = n12_r;
  assign out_ch.shade_index = shade_r;
  assign out_ch.glyph       = glyph_r;

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !rdy[0] |=> v_r[0])
    else $error("first stage dropped a stalled word");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted word did not enter the pipeline");

  a_drain_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input blocked while output drains");

  a_glyph_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.shade_index == 8'd0 |-> out_ch.glyph == fvn_pkg::RAMP[0])
    else $error("glyph does not match zero shade");

  a_glyph_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.shade_index == 8'd255 |-> out_ch.glyph == fvn_pkg::RAMP[5])
    else $error("glyph does not match full shade");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fbm_value_noise_shader: pixels are driven on
// valid/ready with random idling, and each shade word is compared with a
// built-in fbm predictor. Depends on fvn_pkg and the interfaces in fvn_if.sv.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 30;

  typedef struct packed {
    logic [15:0] noise_value;
    logic [7:0]  shade_index;
    logic [7:0]  glyph;
  } shade_word_t;

  typedef struct packed {
    logic [fvn_pkg::COORD_W-1:0] column;
    logic [fvn_pkg::COORD_W-1:0] row;
    logic [fvn_pkg::TIME_W-1:0]  time_coord;
  } pixel_t;

  logic clk;
  logic rst_n;
  int unsigned cycle_cnt;
  int unsigned fail_cnt;
  int unsigned pixels_sent;
  int unsigned words_seen;
  int unsigned cfg_writes;
  bit quiet_tail;

  fvn_in_if  in_bus();
  fvn_out_if out_bus();
  fvn_cfg_if cfg_bus();

  fbm_value_noise_shader u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor state
  logic [15:0] col_step_q;
  logic [15:0] row_step_q;
  logic [15:0] band_rom [fvn_pkg::SINE_N];
  shade_word_t shade_q [$];

  function automatic logic [31:0] avalanche(logic [31:0] h);
    h = h ^ (h >> 16);
    h = h * 32'h7feb352d;
    h = h ^ (h >> 15);
    h = h * 32'h846ca68b;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic logic [15:0] corner_value(logic [15:0] ix, logic [15:0] iy,
                                               logic [15:0] iz);
    logic [31:0] h;
    h = (32'(ix) * 32'd73856093) ^ (32'(iy) * 32'd19349663) ^ (32'(iz) * 32'd83492791);
    h = avalanche(h);
    return h[31:16];
  endfunction

  function automatic logic [15:0] quintic(logic [15:0] t);
    logic [63:0] t2, t3, t4, t5;
    longint s;
    t2 = (64'(t) * 64'(t) + 64'd32768) >> 16;
    t3 = (t2 * 64'(t) + 64'd32768) >> 16;
    t4 = (t3 * 64'(t) + 64'd32768) >> 16;
    t5 = (t4 * 64'(t) + 64'd32768) >> 16;
    s = 10 * longint'(t3) - 15 * longint'(t4) + 6 * longint'(t5);
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    return 16'(s);
  endfunction

  function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [15:0] s);
    longint p;
    p = longint'(s) * (longint'(b) - longint'(a)) + 32768;
    return 16'(longint'(a) + (p >>> 16));
  endfunction

  function automatic logic [15:0] lattice_noise(logic [31:0] cx, logic [31:0] cy,
                                                logic [31:0] cz);
    logic [15:0] x0, y0, z0, x1, y1, z1, sx, sy, sz, a00, a10, a01, a11, b0, b1;
    x0 = cx[31:16];
    y0 = cy[31:16];
    z0 = cz[31:16];
    x1 = x0 + 16'd1;
    y1 = y0 + 16'd1;
    z1 = z0 + 16'd1;
    sx = quintic(cx[15:0]);
    sy = quintic(cy[15:0]);
    sz = quintic(cz[15:0]);
    a00 = blend(corner_value(x0, y0, z0), corner_value(x1, y0, z0), sx);
    a10 = blend(corner_value(x0, y1, z0), corner_value(x1, y1, z0), sx);
    a01 = blend(corner_value(x0, y0, z1), corner_value(x1, y0, z1), sx);
    a11 = blend(corner_value(x0, y1, z1), corner_value(x1, y1, z1), sx);
    b0 = blend(a00, a10, sy);
    b1 = blend(a01, a11, sy);
    return blend(b0, b1, sz);
  endfunction

  function automatic logic [63:0] taylor_sine(logic [63:0] x);
    logic [63:0] x2, term, pos, neg;
    x2 = (x * x) >> 30;
    term = x;
    pos = x;
    neg = 0;
    for (int j = 1; j <= 7; j++) begin
      term = ((term * x2) >> 30) / 64'((2 * j) * (2 * j + 1));
      if (j % 2 == 1) neg += term;
      else pos += term;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  task automatic fill_band_rom();
    int unsigned q, kk;
    bit negative;
    logic [63:0] mag;
    longint v;
    q = fvn_pkg::SINE_N / 4;
    for (int unsigned k = 0; k < fvn_pkg::SINE_N; k++) begin
      negative = 1'b0;
      if (k <= q) kk = k;
      else if (k < 2 * q) kk = 2 * q - k;
      else if (k < 3 * q) begin
        kk = k - 2 * q;
        negative = 1'b1;
      end else begin
        kk = fvn_pkg::SINE_N - k;
        negative = 1'b1;
      end
      mag = (taylor_sine((64'(kk) * 64'd6746518852) >> fvn_pkg::SINE_BITS) + 64'd16384) >> 15;
      v = negative ? 32768 - longint'(mag) : 32768 + longint'(mag);
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      band_rom[k] = 16'(v);
    end
  endtask

  function automatic shade_word_t shade_pixel(pixel_t px);
    logic [31:0] cx, cy, cz;
    logic [63:0] total, n, mix, shade, phase, k;
    logic [7:0] gradient [6];
    shade_word_t w;
    gradient = '{8'h20, 8'h2E, 8'h2B, 8'h31, 8'h30, 8'h30};
    cx = 32'(px.column) * 32'(col_step_q);
    cy = 32'(px.row) * 32'(row_step_q);
    cz = px.time_coord;
    total = 0;
    for (int i = 0; i < fvn_pkg::OCTAVES; i++)
      total += 64'(lattice_noise(cx << i, cy << i, cz << i)) << (fvn_pkg::OCTAVES - 1 - i);
    n = (total + 64'd7) / 64'd15;
    if (n > 65535) n = 65535;
    phase = (n * 5) & 64'hFFFF;
    k = (phase + 64'(fvn_pkg::SINE_HALF)) >> (16 - fvn_pkg::SINE_BITS);
    mix = 64'd42598 * n + 64'd22938 * 64'(band_rom[k % fvn_pkg::SINE_N]);
    shade = (mix * 255 + 64'h8000_0000) >> 32;
    if (shade > 255) shade = 255;
    w.noise_value = n[15:0];
    w.shade_index = shade[7:0];
    w.glyph = gradient[(shade * 10 + 255) / 510];
    return w;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, words_seen);
    fail_cnt++;
  endtask

  // result side: random stalls and checking
  int unsigned stall_left;
  initial begin
    out_bus.ready = 1'b0;
    stall_left = 0;
  end
  always @(negedge clk) begin
    if (quiet_tail) out_bus.ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_bus.ready <= 1'b0;
    end else out_bus.ready <= 1'b1;
  end

  always @(posedge clk) begin
    shade_word_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      words_seen++;
      if (shade_q.size() == 0) report_mismatch("unexpected word", 1, 0);
      else begin
        want = shade_q.pop_front();
        if (out_bus.noise_value !== want.noise_value)
          report_mismatch("noise_value", out_bus.noise_value, want.noise_value);
        if (out_bus.shade_index !== want.shade_index)
          report_mismatch("shade_index", out_bus.shade_index, want.shade_index);
        if (out_bus.glyph !== want.glyph)
          report_mismatch("glyph", out_bus.glyph, want.glyph);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", shade_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // pixel side
  task automatic send_pixel(pixel_t px);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.column = px.column;
    in_bus.row = px.row;
    in_bus.time_coord = px.time_coord;
    do @(posedge clk); while (!in_bus.ready);
    shade_q.push_back(shade_pixel(px));
    pixels_sent++;
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic drain();
    while (shade_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [fvn_pkg::CFG_IDX_W-1:0] idx,
                           logic [fvn_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == fvn_pkg::REG_COLUMN_STEP) col_step_q = data;
    else if (idx == fvn_pkg::REG_ROW_STEP) row_step_q = data;
    cfg_writes++;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.column = fvn_pkg::COORD_W'($urandom);
    px.row = fvn_pkg::COORD_W'($urandom);
    case ($urandom_range(0, 3))
      0: px.time_coord = $urandom_range(0, 32'h0003_FFFF);
      1: px.time_coord = {16'($urandom_range(16'hFFF0, 16'hFFFF)), 16'($urandom)};
      default: px.time_coord = $urandom;
    endcase
    return px;
  endfunction

  pixel_t directed [] = '{
    '{12'd0,    12'd0,    32'h0000_0000},
    '{12'd4095, 12'd0,    32'h0000_0000},
    '{12'd0,    12'd4095, 32'h0000_0000},
    '{12'd4095, 12'd4095, 32'hFFFF_FFFF},
    '{12'd0,    12'd0,    32'hFFFF_FFFF},
    '{12'd0,    12'd0,    32'h0000_FFFF},
    '{12'd0,    12'd0,    32'h0001_0000},
    '{12'd0,    12'd0,    32'h0000_8000},
    '{12'd0,    12'd0,    32'h8000_0000},
    '{12'd0,    12'd0,    32'hFFFF_0000},
    '{12'd0,    12'd0,    32'h1000_0000},
    '{12'd100,  12'd100,  32'h0000_0000},
    '{12'd2048, 12'd2048, 32'h5555_5555},
    '{12'd2047, 12'd1,    32'hAAAA_AAAA},
    '{12'd1,    12'd2047, 32'h7FFF_FFFF},
    '{12'd4094, 12'd17,   32'h0123_4567},
    '{12'd777,  12'd3333, 32'hFEDC_BA98}
  };

  logic [15:0] step_plan [6][2] = '{
    '{16'd0, 16'd0}, '{16'hFFFF, 16'hFFFF}, '{16'd1, 16'hFFFF},
    '{16'hFFFF, 16'd0}, '{16'd4000, 16'd9000}, '{16'd655, 16'd328}
  };

  initial begin
    rst_n = 1'b0;
    cycle_cnt = 0;
    fail_cnt = 0;
    pixels_sent = 0;
    words_seen = 0;
    cfg_writes = 0;
    quiet_tail = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.column = '0;
    in_bus.row = '0;
    in_bus.time_coord = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    col_step_q = fvn_pkg::COLUMN_STEP_RST;
    row_step_q = fvn_pkg::ROW_STEP_RST;
    fill_band_rom();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_pixel(directed[i]);
    for (int i = 0; i < 80; i++) send_pixel(random_pixel());
    drain();

    foreach (step_plan[p]) begin
      write_reg(fvn_pkg::REG_COLUMN_STEP, step_plan[p][0]);
      write_reg(fvn_pkg::REG_ROW_STEP, step_plan[p][1]);
      write_reg(fvn_pkg::CFG_IDX_W'($urandom_range(2, 255)), 16'($urandom));
      foreach (directed[i]) if (i < 6) send_pixel(directed[i]);
      for (int i = 0; i < 110; i++) begin
        if (i == 55 && p == 2) drain();
        send_pixel(random_pixel());
      end
      drain();
    end

    write_reg(fvn_pkg::REG_COLUMN_STEP, 16'($urandom));
    write_reg(fvn_pkg::REG_ROW_STEP, 16'($urandom));
    quiet_tail = 1'b1;
    for (int i = 0; i < 257; i++) send_pixel(random_pixel());
    drain();

    $display("covered %0d pixels and %0d register writes over %0d step settings,",
             pixels_sent, cfg_writes, 8);
    $display("checked %0d shade words, %0d mismatches", words_seen, fail_cnt);
    if (fail_cnt == 0 && shade_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fvn_pkg.sv
rtl/fvn_if.sv
rtl/fbm_value_noise_shader.sv
tb/testbench.sv
